@@ rtl/stream_pattern_first_match_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stream pattern first-match core
// Clocked, reset-qualified property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef STREAM_PATTERN_FIRST_MATCH_CORE_ASSERT_SVH
`define STREAM_PATTERN_FIRST_MATCH_CORE_ASSERT_SVH

// same-cycle implication
`define SPFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spfm: same-cycle check failed");

// next-cycle implication
`define SPFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spfm: next-cycle check failed");

`endif

@@ rtl/spfm_pkg.sv @@
// ----------------------------------------------------------------------------
// spfm_pkg
// Shared types and constants of the stream pattern first-match core.
// ----------------------------------------------------------------------------
`default_nettype none

package spfm_pkg;

	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 32;
	localparam int CFG_W    = 64;
	localparam int LEN_REG_W = 5;

	typedef enum logic [1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2,
		REG_REPORT_END     = 2'd3
	} cfg_reg_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic              clear;
		logic              step;
		logic [BYTE_W-1:0] data;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/stream_pattern_first_match_core.sv @@
// Finds the first occurrence of a configured pattern of up to PATTERN_BYTES
// bytes in a byte stream and returns one result per stream: found with the
// offset of the match start (or just past its end, per report_end), or not
// found at stream end; the rest of a stream after a match is dropped. One input
// transaction is taken every clock while s_tready is high; its result goes to the
// main output register, or to the skid register while main holds an untaken result.
// Cells and byte counter give match and offset combinationally. A two-entry output
// buffer lets input continue while a result waits; s_tready falls only when both
// entries hold results. Configuration must be written while the block is idle (not enforced).
// ----------------------------------------------------------------------------
// stream_pattern_first_match_core
// Shift-and exact string match over a row of byte-compare cells.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_pattern_first_match_core #(
	parameter int PATTERN_BYTES = 16,
	parameter int OFFSET_BITS   = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [spfm_pkg::CFG_W-1:0]        cfg_data,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [spfm_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] data_byte
	input  wire logic [1:0]                        s_tuser,  // [0] carries_byte, [1] starts_stream
	input  wire logic                              s_tlast,  // ends_stream
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [spfm_pkg::OFFSET_W-1:0]          m_tdata,  // [31:0] offset
	output logic                                   m_tuser   // [0] found
);

	`include "stream_pattern_first_match_core_assert.svh"

	localparam int BW    = spfm_pkg::BYTE_W;
	localparam int OUT_W = spfm_pkg::OFFSET_W;
	localparam int LEN_W = $clog2(PATTERN_BYTES + 1);
	localparam int LRW   = spfm_pkg::LEN_REG_W;

	// configuration state
	logic [BW-1:0]            pat_q [PATTERN_BYTES];
	logic [LEN_W-1:0]         len_q;
	logic [PATTERN_BYTES-1:0] en_q;
	logic [PATTERN_BYTES-1:0] last_q;
	logic                     report_end_q;
	logic [LEN_W-1:0]         len_new;
	logic [LRW-1:0]           len_raw;

	assign len_raw = cfg_data[LRW-1:0];

	always_comb begin
		if (len_raw == '0) begin
			len_new = LEN_W'(1);
		end else if (32'(len_raw) > 32'(PATTERN_BYTES)) begin
			len_new = LEN_W'(PATTERN_BYTES);
		end else begin
			len_new = LEN_W'(len_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_BYTES; i++) begin
				pat_q[i]  <= '0;
				en_q[i]   <= (i == 0);
				last_q[i] <= (i == 0);
			end
			len_q        <= LEN_W'(1);
			report_end_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				spfm_pkg::REG_PATTERN_LOW: begin
					for (int i = 0; i < PATTERN_BYTES; i++) begin
						if (i < 8) begin
							pat_q[i] <= cfg_data[(i % 8) * BW +: BW];
						end
					end
				end
				spfm_pkg::REG_PATTERN_HIGH: begin
					for (int i = 0; i < PATTERN_BYTES; i++) begin
						if (i >= 8) begin
							pat_q[i] <= cfg_data[(i % 8) * BW +: BW];
						end
					end
				end
				spfm_pkg::REG_PATTERN_LENGTH: begin
					len_q <= len_new;
					for (int i = 0; i < PATTERN_BYTES; i++) begin
						en_q[i]   <= (i < int'(len_new));
						last_q[i] <= (i == int'(len_new) - 1);
					end
				end
				spfm_pkg::REG_REPORT_END: begin
					report_end_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// input decode
	logic accept, has_byte, start, fin;
	logic done_q, done_eff;
	logic [OFFSET_BITS-1:0] cnt_q, cnt_eff, cnt_next;
	spfm_pkg::cell_ctrl_t ctrl;

	assign accept   = s_tvalid & s_tready;
	assign has_byte = s_tuser[0];
	assign start    = s_tuser[1];
	assign fin      = s_tlast;
	assign done_eff = done_q & ~start;
	assign cnt_eff  = start ? '0 : cnt_q;
	assign cnt_next = (cnt_eff == '1) ? cnt_eff : cnt_eff + OFFSET_BITS'(1);

	assign ctrl.clear = accept & start;
	assign ctrl.step  = accept & ~done_eff & has_byte;
	assign ctrl.data  = s_tdata;

	// row of cells
	logic [PATTERN_BYTES-1:0] pm_q, hit_vec, prev_vec;

	for (genvar g = 0; g < PATTERN_BYTES; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign prev_vec[g] = 1'b1;
		end else begin : g_body
			assign prev_vec[g] = pm_q[g-1] & ~ctrl.clear;
		end
		spfm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.pat_byte(pat_q[g]),
			.enable  (en_q[g]),
			.is_last (last_q[g]),
			.prev    (prev_vec[g]),
			.state_q (pm_q[g]),
			.hit     (hit_vec[g])
		);
	end

	// result
	logic match, push, res_found;
	logic [OFFSET_BITS-1:0] len_ext, off_full;
	logic [OUT_W-1:0] res_off;

	assign match     = ctrl.step & (|hit_vec);
	assign push      = accept & ~done_eff & (match | fin);
	assign res_found = match;
	assign len_ext   = OFFSET_BITS'(len_q);

	always_comb begin
		if (report_end_q) begin
			off_full = cnt_next;
		end else if (cnt_next >= len_ext) begin
			off_full = cnt_next - len_ext;
		end else begin
			off_full = '0;
		end
	end

	assign res_off = res_found ? OUT_W'(off_full) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			done_q <= done_eff | push;
			if (ctrl.step) begin
				cnt_q <= cnt_next;
			end else if (start) begin
				cnt_q <= '0;
			end
		end
	end

	// two-entry output buffer: main register and skid register
	logic             main_q, skid_q, pop;
	logic             main_found_q, skid_found_q;
	logic [OUT_W-1:0] main_off_q, skid_off_q;

	assign pop      = main_q & m_tready;
	assign s_tready = ~skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q <= 1'b0;
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (pop) begin
				skid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_q && !pop) begin
				skid_q <= 1'b1;
			end else begin
				main_q <= 1'b1;
			end
		end else if (pop) begin
			main_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_q) begin
			if (pop) begin
				main_found_q <= skid_found_q;
				main_off_q   <= skid_off_q;
			end
		end else if (push) begin
			if (main_q && !pop) begin
				skid_found_q <= res_found;
				skid_off_q   <= res_off;
			end else begin
				main_found_q <= res_found;
				main_off_q   <= res_off;
			end
		end
	end

	assign m_tvalid = main_q;
	assign m_tdata  = main_off_q;
	assign m_tuser  = main_found_q;

	// checks
	`SPFM_ASSERT_NOW(a_skid_implies_main, clk, arst_n, skid_q, main_q)
	`SPFM_ASSERT_NOW(a_notfound_zero, clk, arst_n, main_q && !main_found_q, main_off_q == '0)
	`SPFM_ASSERT_NEXT(a_result_sets_done, clk, arst_n, push, done_q)
	`SPFM_ASSERT_NOW(a_done_blocks, clk, arst_n, accept && done_q && !start, !push)

endmodule

`default_nettype wire

@@ rtl/spfm_cell.sv @@
// ----------------------------------------------------------------------------
// spfm_cell
// One pattern position: compares the stream byte with its pattern byte and
// keeps one bit of the shift-and partial-match vector.
// ----------------------------------------------------------------------------
`default_nettype none

module spfm_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire spfm_pkg::cell_ctrl_t           ctrl,
	input  wire logic [spfm_pkg::BYTE_W-1:0]    pat_byte,
	input  wire logic                           enable,
	input  wire logic                           is_last,
	input  wire logic                           prev,
	output logic                                state_q,
	output logic                                hit
);

	logic next_bit;

	// prev is the neighbour's bit, already cleared for a stream start
	assign next_bit = prev & enable & (ctrl.data == pat_byte);
	assign hit      = next_bit & is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 1'b0;
		end else if (ctrl.step) begin
			state_q <= next_bit;
		end else if (ctrl.clear) begin
			state_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire
